/* rtl/led_timed_action_controller_core_defines.svh */
// Assertion macros shared by the LED controller RTL.
// Each macro evaluates on the rising edge of clk and is disabled during rst.
`ifndef LED_TIMED_ACTION_CONTROLLER_CORE_DEFINES_SVH
`define LED_TIMED_ACTION_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LTAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ltac assertion failed");

// Next-cycle implication.
`define LTAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ltac assertion failed");

`else

`define LTAC_ASSERT_IMP(label, ante, cons)
`define LTAC_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/ltac_pkg.sv */
`default_nettype none

package ltac_pkg;

  // Width of the fixed input fields
  localparam int OP_W      = 3;
  localparam int IN_TIME_W = 24;
  localparam int EXT_W     = 32;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
  localparam logic [OP_W-1:0] OP_BLINK  = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

  // Per-slot action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;
  localparam logic [1:0] ACT_BLINK = 2'd3;

  // Per-channel control flags stored with the timers
  typedef struct packed {
    logic [1:0] act_main;
    logic [1:0] act_temp;
    logic       use_temp;
    logic       delay_on;
  } ltac_flags_t;

  localparam int FLAGS_W = $bits(ltac_flags_t);

  // Command bits handed to the channel update logic
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            level;
    logic            restore_after;
    logic            cancel_stored;
  } ltac_cmd_t;

endpackage

`default_nettype wire

/* rtl/ltac_chan_mem.sv */
`default_nettype none

module ltac_chan_mem
  import ltac_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 126
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [DATA_W-1:0] rd_q;
  logic              rd_ok;

  // Storage array, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Entries never written read as the reset value (all zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_ok <= written[raddr];
      end
    end
  end

  assign rdata = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

/* rtl/ltac_chan_update.sv */
`default_nettype none

module ltac_chan_update
  import ltac_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input  wire ltac_cmd_t             cmd,
  input  wire logic [TIME_BITS-1:0]  dur,
  input  wire logic [TIME_BITS-1:0]  dur_off,
  input  wire logic [TIME_BITS-1:0]  dly,
  input  wire ltac_flags_t           flags_in,
  input  wire logic [TIME_BITS-1:0]  on_main_in,
  input  wire logic [TIME_BITS-1:0]  off_main_in,
  input  wire logic [TIME_BITS-1:0]  on_temp_in,
  input  wire logic [TIME_BITS-1:0]  off_temp_in,
  input  wire logic [TIME_BITS-1:0]  count_in,
  input  wire logic                  pin_in,
  output ltac_flags_t                flags_out,
  output logic      [TIME_BITS-1:0]  on_main_out,
  output logic      [TIME_BITS-1:0]  off_main_out,
  output logic      [TIME_BITS-1:0]  on_temp_out,
  output logic      [TIME_BITS-1:0]  off_temp_out,
  output logic      [TIME_BITS-1:0]  count_out,
  output logic                       pin_out,
  output logic                       running_out
);

  localparam logic [TIME_BITS-1:0] T_ZERO = '0;
  localparam logic [TIME_BITS-1:0] T_ONE  = TIME_BITS'(1);

  logic [1:0]           act_v [2];
  logic [TIME_BITS-1:0] on_v  [2];
  logic [TIME_BITS-1:0] off_v [2];
  logic                 ut_v;
  logic                 dly_v;
  logic [TIME_BITS-1:0] cnt_v;
  logic                 pin_v;
  logic                 lvl_v;
  logic                 stop_req;
  logic                 stop_cancel;
  logic                 restored;

  // One read-modify-write step on a channel entry
  always_comb begin
    act_v[0]    = flags_in.act_main;
    act_v[1]    = flags_in.act_temp;
    on_v[0]     = on_main_in;
    off_v[0]    = off_main_in;
    on_v[1]     = on_temp_in;
    off_v[1]    = off_temp_in;
    ut_v        = flags_in.use_temp;
    dly_v       = flags_in.delay_on;
    cnt_v       = count_in;
    pin_v       = pin_in;
    lvl_v       = cmd.level;
    stop_req    = 1'b0;
    stop_cancel = 1'b0;
    restored    = 1'b0;

    case (cmd.op)
      OP_TICK: begin
        if (act_v[ut_v] != ACT_NONE) begin
          if (cnt_v > T_ONE) begin
            cnt_v = cnt_v - T_ONE;
          end else if (dly_v) begin
            // start delay over: begin the stored action
            dly_v = 1'b0;
            case (act_v[ut_v])
              ACT_ON: begin
                pin_v = 1'b1;
                if (on_v[ut_v] != T_ZERO) cnt_v = on_v[ut_v];
                else stop_req = 1'b1;
              end
              ACT_OFF: begin
                pin_v = 1'b0;
                if (off_v[ut_v] != T_ZERO) cnt_v = off_v[ut_v];
                else stop_req = 1'b1;
              end
              ACT_BLINK: begin
                pin_v = !pin_v;
                cnt_v = pin_v ? on_v[ut_v] : off_v[ut_v];
              end
              default: ;
            endcase
          end else begin
            // timed action ends, or blink phase flips
            case (act_v[ut_v])
              ACT_ON: begin
                pin_v    = 1'b0;
                stop_req = 1'b1;
              end
              ACT_OFF: begin
                pin_v    = 1'b1;
                stop_req = 1'b1;
              end
              ACT_BLINK: begin
                cnt_v = pin_v ? off_v[ut_v] : on_v[ut_v];
                pin_v = !pin_v;
              end
              default: ;
            endcase
          end
        end
      end

      OP_SET, OP_TOGGLE: begin
        if (cmd.op == OP_TOGGLE) lvl_v = !pin_in;
        if (dur == T_ZERO && dly == T_ZERO) begin
          act_v[ut_v] = ACT_NONE;
          pin_v       = lvl_v;
        end else begin
          if (cmd.restore_after) ut_v = 1'b1;
          if (dly != T_ZERO) begin
            dly_v = 1'b1;
            cnt_v = dly;
            if (lvl_v) on_v[ut_v] = dur;
            else off_v[ut_v] = dur;
          end else begin
            dly_v = 1'b0;
            cnt_v = dur;
            pin_v = lvl_v;
          end
          act_v[ut_v] = lvl_v ? ACT_ON : ACT_OFF;
        end
      end

      OP_BLINK: begin
        if (dly == T_ZERO) pin_v = lvl_v;
        if (dur != T_ZERO) begin
          on_v[ut_v]  = dur;
          off_v[ut_v] = (dur_off == T_ZERO) ? dur : dur_off;
          if (dly != T_ZERO) begin
            dly_v = 1'b1;
            cnt_v = dly;
          end else begin
            cnt_v = lvl_v ? dur : off_v[ut_v];
          end
          act_v[ut_v] = ACT_BLINK;
        end
      end

      OP_STOP: begin
        stop_req    = 1'b1;
        stop_cancel = cmd.cancel_stored;
      end

      default: ;
    endcase

    // Stop: from temp, reload main timer unless cancelled; else clear action
    if (stop_req) begin
      if (ut_v) begin
        ut_v     = 1'b0;
        restored = 1'b1;
        if (!stop_cancel) begin
          case (act_v[0])
            ACT_ON:    cnt_v = on_v[0];
            ACT_OFF:   cnt_v = off_v[0];
            ACT_BLINK: cnt_v = pin_v ? off_v[0] : on_v[0];
            default:   ;
          endcase
        end
      end
      if (!restored || stop_cancel) act_v[ut_v] = ACT_NONE;
    end
  end

  assign flags_out.act_main = act_v[0];
  assign flags_out.act_temp = act_v[1];
  assign flags_out.use_temp = ut_v;
  assign flags_out.delay_on = dly_v;
  assign on_main_out        = on_v[0];
  assign off_main_out       = off_v[0];
  assign on_temp_out        = on_v[1];
  assign off_temp_out       = off_v[1];
  assign count_out          = cnt_v;
  assign pin_out            = pin_v;
  assign running_out        = (act_v[ut_v] != ACT_NONE);

endmodule

`default_nettype wire

/* rtl/led_timed_action_controller_core.sv */
// LED timed action controller.
// Input channel (in_valid / in_stall) carries one transaction per command or
// tick; output channel (out_valid / out_stall) returns one transaction per
// input: all pin levels plus the addressed channel's running and lit flags.
// Per-channel state (action flags, main and temp on/off times, countdown)
// lives in one single-port-read, single-port-write memory; pins are flops.
// A command reads its entry, updates it and writes it back, then loads the
// output register. A tick sweeps every channel through the memory, one
// read-modify-write per cycle, before its result is loaded.
// The memory read/write ports set this sequence.
// in_stall is high while an item is in progress; a finished result waits in
// the output register while the next item is taken. If the output register
// is still stalled when a new result is ready, the block holds that result
// until the output frees up.
// Reset (rst, synchronous) holds in_stall high, turns all LEDs off and marks
// every channel entry as unwritten, so it reads as idle with zero times.
`default_nettype none

`include "led_timed_action_controller_core_defines.svh"

module led_timed_action_controller_core
  import ltac_pkg::*;
#(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      op,
  input  wire logic [2:0]           channel,
  input  wire logic                 level,
  input  wire logic [IN_TIME_W-1:0] duration,
  input  wire logic [IN_TIME_W-1:0] duration_off,
  input  wire logic [IN_TIME_W-1:0] start_delay,
  input  wire logic                 restore_after,
  input  wire logic                 cancel_stored,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [7:0]           pin_levels,
  output logic                      running,
  output logic                      lit
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = FLAGS_W + 5 * TIME_BITS;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  ltac_cmd_t            cmd_q;
  logic [2:0]           ch_q;
  logic                 ch_ok;
  logic [TIME_BITS-1:0] dur_q;
  logic [TIME_BITS-1:0] doff_q;
  logic [TIME_BITS-1:0] dly_q;
  logic [CH_W-1:0]      idx;
  logic [CHANNELS-1:0]  pins;
  logic                 run_q;
  logic                 lit_q;

  logic                 accept;
  logic                 is_tick;
  logic                 out_free;
  logic [EXT_W-1:0]     dur_ext;
  logic [EXT_W-1:0]     doff_ext;
  logic [EXT_W-1:0]     dly_ext;

  logic                 mem_we;
  logic                 mem_re;
  logic [CH_W-1:0]      mem_raddr;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [ENTRY_W-1:0]   wr_entry;

  ltac_flags_t          rd_flags;
  logic [TIME_BITS-1:0] rd_on0, rd_off0, rd_on1, rd_off1, rd_cnt;
  ltac_flags_t          wr_flags;
  logic [TIME_BITS-1:0] wr_on0, wr_off0, wr_on1, wr_off1, wr_cnt;
  logic                 new_pin;
  logic                 new_run;

  // Handshake and sweep control
  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != ST_IDLE);
  assign is_tick  = (cmd_q.op == OP_TICK);
  assign out_free = !out_valid || !out_stall;

  assign dur_ext  = EXT_W'(duration);
  assign doff_ext = EXT_W'(duration_off);
  assign dly_ext  = EXT_W'(start_delay);

  // Memory port: first read at accept, sweep reads one entry ahead of the write
  assign mem_re    = accept || (state == ST_RUN && is_tick && idx != LAST_CH);
  assign mem_raddr = accept ? ((op == OP_TICK) ? '0 : CH_W'(channel))
                            : idx + 1'b1;
  assign mem_we    = (state == ST_RUN) && (is_tick || ch_ok);

  assign {rd_flags, rd_on0, rd_off0, rd_on1, rd_off1, rd_cnt} = rd_entry;
  assign wr_entry = {wr_flags, wr_on0, wr_off0, wr_on1, wr_off1, wr_cnt};

  ltac_chan_mem #(
    .DEPTH  (CHANNELS),
    .ADDR_W (CH_W),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (idx),
    .wdata (wr_entry),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  ltac_chan_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cmd          (cmd_q),
    .dur          (dur_q),
    .dur_off      (doff_q),
    .dly          (dly_q),
    .flags_in     (rd_flags),
    .on_main_in   (rd_on0),
    .off_main_in  (rd_off0),
    .on_temp_in   (rd_on1),
    .off_temp_in  (rd_off1),
    .count_in     (rd_cnt),
    .pin_in       (pins[idx]),
    .flags_out    (wr_flags),
    .on_main_out  (wr_on0),
    .off_main_out (wr_off0),
    .on_temp_out  (wr_on1),
    .off_temp_out (wr_off1),
    .count_out    (wr_cnt),
    .pin_out      (new_pin),
    .running_out  (new_run)
  );

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q.op            <= op;
      cmd_q.level         <= level;
      cmd_q.restore_after <= restore_after;
      cmd_q.cancel_stored <= cancel_stored;
      ch_q                <= channel;
      dur_q               <= dur_ext[TIME_BITS-1:0];
      doff_q              <= doff_ext[TIME_BITS-1:0];
      dly_q               <= dly_ext[TIME_BITS-1:0];
    end
  end

  // Sequencer, pin register and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pins  <= '0;
      ch_ok <= 1'b0;
      idx   <= '0;
      run_q <= 1'b0;
      lit_q <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            ch_ok <= (32'(channel) < CHANNELS);
            idx   <= (op == OP_TICK) ? '0 : CH_W'(channel);
            run_q <= 1'b0;
            lit_q <= 1'b0;
          end
        end
        ST_RUN: begin
          if (mem_we) begin
            pins[idx] <= new_pin;
          end
          if (mem_we && ch_ok && idx == CH_W'(ch_q)) begin
            run_q <= new_run;
            lit_q <= new_pin;
          end
          if (!is_tick || idx == LAST_CH) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      pin_levels <= 8'(pins);
      running    <= run_q;
      lit        <= lit_q;
    end
  end

  // Checks
  `LTAC_ASSERT_IMP(a_no_rw_same_entry, mem_we && mem_re, idx != mem_raddr)
  `LTAC_ASSERT_NXT(a_accept_starts_run, accept, state == ST_RUN)
  `LTAC_ASSERT_NXT(a_sweep_advances, state == ST_RUN && is_tick && idx != LAST_CH,
                   state == ST_RUN && idx == $past(idx) + 1'b1)
  `LTAC_ASSERT_NXT(a_done_loads_result, state == ST_DONE && out_free, out_valid)

endmodule

`default_nettype wire

/* dv/led_timed_action_controller_core_test.sv */
`timescale 1ns / 100ps

module led_timed_action_controller_core_test;
  import ltac_pkg::*;

  localparam int NCH          = 8;
  localparam int TB           = IN_TIME_W;
  localparam int CMD_COUNT    = 1950;
  localparam int LIMIT_CYCLES = 300000;
  localparam int LONG_HOLD    = 250;
  localparam int TAIL_QUIET   = 150;

  // Op codes the block has no meaning for
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [2:0]      channel;
    logic            level;
    logic [TB-1:0]   duration;
    logic [TB-1:0]   duration_off;
    logic [TB-1:0]   start_delay;
    logic            restore_after;
    logic            cancel_stored;
    logic            drain_first;
  } led_cmd_t;

  typedef struct packed {
    logic [7:0] pins;
    logic       running;
    logic       lit;
  } led_status_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [OP_W-1:0] op = OP_TICK;
  logic [2:0]    channel = 3'd0;
  logic          level = 1'b0;
  logic [TB-1:0] duration = '0;
  logic [TB-1:0] duration_off = '0;
  logic [TB-1:0] start_delay = '0;
  logic          restore_after = 1'b0;
  logic          cancel_stored = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [7:0]    pin_levels;
  logic          running;
  logic          lit;

  led_timed_action_controller_core #(
    .CHANNELS (NCH),
    .TIME_BITS(TB)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .channel      (channel),
    .level        (level),
    .duration     (duration),
    .duration_off (duration_off),
    .start_delay  (start_delay),
    .restore_after(restore_after),
    .cancel_stored(cancel_stored),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_levels   (pin_levels),
    .running      (running),
    .lit          (lit)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the LED state
  logic [7:0]    pin_q;
  logic [1:0]    act_q [0:1][0:NCH-1];
  bit            use_tmp [0:NCH-1];
  bit            in_delay [0:NCH-1];
  logic [TB-1:0] on_q [0:1][0:NCH-1];
  logic [TB-1:0] off_q [0:1][0:NCH-1];
  logic [TB-1:0] cnt_q [0:NCH-1];

  led_cmd_t    cmd_q [$];
  led_status_t status_q [$];
  led_cmd_t    cur;
  led_status_t want;
  bit          drain_next = 0;
  int          total_cmds = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic void clear_leds();
    pin_q = '0;
    for (int c = 0; c < NCH; c++) begin
      use_tmp[c] = 0;
      in_delay[c] = 0;
      cnt_q[c] = '0;
      for (int s = 0; s < 2; s++) begin
        act_q[s][c] = ACT_NONE;
        on_q[s][c] = '0;
        off_q[s][c] = '0;
      end
    end
  endfunction

  // Stop: leave temp slot, reloading main unless cancelled; else clear action
  function automatic void stop_channel(int c, bit cancel);
    bit restored;
    restored = 0;
    if (use_tmp[c]) begin
      use_tmp[c] = 0;
      restored = 1;
      if (!cancel) begin
        case (act_q[0][c])
          ACT_ON:    cnt_q[c] = on_q[0][c];
          ACT_OFF:   cnt_q[c] = off_q[0][c];
          ACT_BLINK: cnt_q[c] = pin_q[c] ? off_q[0][c] : on_q[0][c];
          default: ;
        endcase
      end
    end
    if (!restored || cancel) act_q[use_tmp[c]][c] = ACT_NONE;
  endfunction

  // Countdown reached its end on a tick
  function automatic void expire_channel(int c);
    int         s;
    logic [1:0] a;
    bit         nv;
    s = use_tmp[c];
    a = act_q[s][c];
    if (in_delay[c]) begin
      in_delay[c] = 0;
      if (a == ACT_ON) begin
        pin_q[c] = 1'b1;
        if (on_q[s][c] != 0) cnt_q[c] = on_q[s][c];
        else stop_channel(c, 0);
      end else if (a == ACT_OFF) begin
        pin_q[c] = 1'b0;
        if (off_q[s][c] != 0) cnt_q[c] = off_q[s][c];
        else stop_channel(c, 0);
      end else if (a == ACT_BLINK) begin
        nv = !pin_q[c];
        pin_q[c] = nv;
        cnt_q[c] = nv ? on_q[s][c] : off_q[s][c];
      end
    end else begin
      if (a == ACT_ON) begin
        pin_q[c] = 1'b0;
        stop_channel(c, 0);
      end else if (a == ACT_OFF) begin
        pin_q[c] = 1'b1;
        stop_channel(c, 0);
      end else if (a == ACT_BLINK) begin
        // phase length follows the level being entered
        nv = pin_q[c];
        cnt_q[c] = nv ? off_q[s][c] : on_q[s][c];
        pin_q[c] = !nv;
      end
    end
  endfunction

  function automatic void set_channel(int c, bit lvl, logic [TB-1:0] dur,
                                      logic [TB-1:0] dly, bit rest);
    int s;
    if (dur == 0 && dly == 0) begin
      act_q[use_tmp[c]][c] = ACT_NONE;
      pin_q[c] = lvl;
      return;
    end
    if (rest) use_tmp[c] = 1;
    s = use_tmp[c];
    if (dly != 0) begin
      in_delay[c] = 1;
      cnt_q[c] = dly;
      if (lvl) on_q[s][c] = dur;
      else off_q[s][c] = dur;
    end else begin
      in_delay[c] = 0;
      cnt_q[c] = dur;
      pin_q[c] = lvl;
    end
    act_q[s][c] = lvl ? ACT_ON : ACT_OFF;
  endfunction

  function automatic void blink_channel(int c, bit lvl, logic [TB-1:0] t_on,
                                        logic [TB-1:0] t_off, logic [TB-1:0] dly);
    int s;
    s = use_tmp[c];
    if (dly == 0) pin_q[c] = lvl;
    if (t_on != 0) begin
      on_q[s][c] = t_on;
      off_q[s][c] = (t_off == 0) ? t_on : t_off;
      if (dly != 0) begin
        in_delay[c] = 1;
        cnt_q[c] = dly;
      end else begin
        cnt_q[c] = lvl ? on_q[s][c] : off_q[s][c];
      end
      act_q[s][c] = ACT_BLINK;
    end
  endfunction

  // Apply one transaction to the shadow state and return the status it reports
  function automatic led_status_t apply_cmd(led_cmd_t cmd);
    led_status_t r;
    int          ch;
    ch = cmd.channel;
    if (cmd.op == OP_TICK) begin
      for (int c = 0; c < NCH; c++) begin
        if (act_q[use_tmp[c]][c] == ACT_NONE) continue;
        if (cnt_q[c] > 1) cnt_q[c] = cnt_q[c] - 1'b1;
        else expire_channel(c);
      end
    end else begin
      case (cmd.op)
        OP_SET:    set_channel(ch, cmd.level, cmd.duration, cmd.start_delay,
                               cmd.restore_after);
        OP_TOGGLE: set_channel(ch, !pin_q[ch], cmd.duration, cmd.start_delay,
                               cmd.restore_after);
        OP_BLINK:  blink_channel(ch, cmd.level, cmd.duration, cmd.duration_off,
                                 cmd.start_delay);
        OP_STOP:   stop_channel(ch, cmd.cancel_stored);
        default: ;
      endcase
    end
    r.pins = pin_q;
    r.running = (act_q[use_tmp[ch]][ch] != ACT_NONE);
    r.lit = pin_q[ch];
    return r;
  endfunction

  function automatic void add_cmd(logic [OP_W-1:0] o, int ch, bit lvl,
                                  logic [TB-1:0] dur, logic [TB-1:0] doff,
                                  logic [TB-1:0] dly, bit rest, bit cancel);
    led_cmd_t c;
    c.op = o;
    c.channel = 3'(ch);
    c.level = lvl;
    c.duration = dur;
    c.duration_off = doff;
    c.start_delay = dly;
    c.restore_after = rest;
    c.cancel_stored = cancel;
    c.drain_first = drain_next;
    drain_next = 0;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic logic [TB-1:0] any_ticks();
    logic [31:0] r;
    r = $urandom();
    return r[TB-1:0];
  endfunction

  // Mostly short times so that ticks reach expiry, with rare long ones
  function automatic logic [TB-1:0] pick_ticks();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return TB'($urandom_range(0, 4));
    if (k < 17) return TB'($urandom_range(5, 30));
    if (k < 19) return any_ticks();
    return '1;
  endfunction

  function automatic logic [TB-1:0] pick_delay();
    if ($urandom_range(0, 1) == 0) return '0;
    return pick_ticks();
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // One random transaction, or a short main/temp slot sequence
  function automatic void add_random();
    int k;
    int ch;
    k = $urandom_range(0, 99);
    ch = $urandom_range(0, NCH - 1);
    if (k < 38) begin
      add_cmd(OP_TICK, ch, coin(), any_ticks(), any_ticks(), any_ticks(), coin(), coin());
    end else if (k < 52) begin
      add_cmd(OP_SET, ch, coin(), pick_ticks(), any_ticks(), pick_delay(),
              $urandom_range(0, 2) == 0, coin());
    end else if (k < 61) begin
      add_cmd(OP_TOGGLE, ch, coin(), pick_ticks(), any_ticks(), pick_delay(),
              $urandom_range(0, 2) == 0, coin());
    end else if (k < 74) begin
      add_cmd(OP_BLINK, ch, coin(), pick_ticks(), pick_ticks(), pick_delay(),
              coin(), coin());
    end else if (k < 84) begin
      add_cmd(OP_STOP, ch, coin(), any_ticks(), any_ticks(), any_ticks(), coin(), coin());
    end else if (k < 87) begin
      add_cmd(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), ch, coin(), any_ticks(),
              any_ticks(), any_ticks(), coin(), coin());
    end else begin
      // main action, temporary override, then ticks and maybe a stop
      add_cmd(OP_BLINK, ch, coin(), TB'($urandom_range(1, 4)), TB'($urandom_range(0, 4)),
              TB'($urandom_range(0, 2)), 1'b0, coin());
      add_cmd(coin() ? OP_SET : OP_TOGGLE, ch, coin(), TB'($urandom_range(0, 4)),
              any_ticks(), TB'($urandom_range(0, 3)), 1'b1, coin());
      repeat ($urandom_range(1, 8))
        add_cmd(OP_TICK, $urandom_range(0, NCH - 1), coin(), any_ticks(), any_ticks(),
                any_ticks(), coin(), coin());
      if (coin())
        add_cmd(OP_STOP, ch, coin(), any_ticks(), any_ticks(), any_ticks(), coin(), coin());
    end
  endfunction

  // Driver: predicts each accepted transaction and offers the next one
  int accepted = 0;
  int done_cnt = 0;
  int gap_left = 0;
  bit send_idle_ok;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) done_cnt++;
      if (in_valid && !in_stall) begin
        status_q.insert(status_q.size(), apply_cmd(cur));
        accepted++;
      end
      // idle bursts, none while the receiver holds off nor near the end
      send_idle_ok = (accepted < total_cmds - TAIL_QUIET) &&
                     !(accepted > 550 && accepted < 900) && ((accepted / 250) % 4 != 3);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_q[0].drain_first && (accepted != done_cnt)) begin
          in_valid <= 1'b0;
        end else if (send_idle_ok && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          cur = cmd_q.pop_front();
          in_valid <= 1'b1;
          op <= cur.op;
          channel <= cur.channel;
          level <= cur.level;
          duration <= cur.duration;
          duration_off <= cur.duration_off;
          start_delay <= cur.start_delay;
          restore_after <= cur.restore_after;
          cancel_stored <= cur.cancel_stored;
        end
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off
  int  rcv_seen = 0;
  int  stall_left = 0;
  bit  long_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rcv_seen++;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!long_done && rcv_seen >= 600) begin
        long_done = 1;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if ((rcv_seen < total_cmds - TAIL_QUIET) && ((rcv_seen / 300) % 4 != 2) &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pins=%h running=%b lit=%b",
                 $time, pin_levels, running, lit);
      end else begin
        want = status_q.pop_front();
        check_field("pin_levels", want.pins, pin_levels);
        check_field("running", want.running, running);
        check_field("lit", want.lit, lit);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_leds();

    // Directed: reset state, each op, delays, blink defaults, temp slot
    add_cmd(OP_TICK, 0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 0, 1'b1, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 1, 1'b1, 24'd2, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 2, 1'b0, 24'd1, '0, 24'd2, 1'b0, 1'b0);
    add_cmd(OP_TOGGLE, 0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_BLINK, 3, 1'b1, 24'd2, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_BLINK, 4, 1'b0, 24'd1, 24'd3, 24'd1, 1'b0, 1'b0);
    add_cmd(OP_BLINK, 5, 1'b1, '0, 24'd2, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 6, 1'b1, '0, '0, 24'd2, 1'b0, 1'b0);
    add_cmd(OP_BLINK, 7, 1'b1, 24'd3, 24'd1, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 7, 1'b0, 24'd2, '0, '0, 1'b1, 1'b0);
    repeat (4) add_cmd(OP_TICK, 7, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_TOGGLE, 7, 1'b0, 24'd1, '0, 24'd1, 1'b1, 1'b0);
    add_cmd(OP_STOP, 7, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_STOP, 3, 1'b0, '0, '0, '0, 1'b0, 1'b1);
    add_cmd(OP_STOP, 5, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_SET, 4, 1'b1, 24'd3, '0, '0, 1'b1, 1'b0);
    add_cmd(OP_STOP, 4, 1'b0, '0, '0, '0, 1'b0, 1'b1);
    for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
      add_cmd(OP_W'(o), 2, 1'b1, '1, '1, '1, 1'b1, 1'b1);
    add_cmd(OP_BLINK, 6, 1'b0, '1, '1, '1, 1'b1, 1'b1);
    add_cmd(OP_SET, 1, 1'b1, '1, '0, '0, 1'b0, 1'b0);
    add_cmd(OP_TICK, 7, 1'b1, '1, '1, '1, 1'b1, 1'b1);

    // Random part, pausing now and then until all results are back
    drain_next = 1;
    while (cmd_q.size() < CMD_COUNT) begin
      if (cmd_q.size() % 500 == 0) drain_next = 1;
      add_random();
    end
    total_cmds = cmd_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || in_valid || status_q.size() != 0) @(negedge clk);
    repeat (2 * NCH + 20) @(posedge clk);

    if (errors == 0 && status_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
